// ===== hw/rtl/servo_slew_limiter_pwm_defines.svh =====
// assertion macros for the servo slew limiter checker
`ifndef SERVO_SLEW_LIMITER_PWM_DEFINES_SVH
`define SERVO_SLEW_LIMITER_PWM_DEFINES_SVH

// same-cycle implication
`define SSL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ssl_pkg.sv =====
// types, constants and duty table for the servo slew limiter
package ssl_pkg;

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_RAMP     = 3'd1,
		OP_SET      = 3'd2,
		OP_STOP     = 3'd3,
		OP_RECENTRE = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_STEP,
		ST_APPLY,
		ST_DUTY,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic step;
		logic apply;
		logic duty;
		logic out_load;
	} cmd_t;

	localparam logic [2:0] CFG_STEP_INTERVAL = 3'd0;
	localparam logic [2:0] CFG_STEP_SIZE     = 3'd1;
	localparam logic [2:0] CFG_DETACH_EN     = 3'd2;
	localparam logic [2:0] CFG_DETACH_DELAY  = 3'd3;
	localparam logic [2:0] CFG_MIN_ANGLE     = 3'd4;
	localparam logic [2:0] CFG_MAX_ANGLE     = 3'd5;
	localparam logic [2:0] CFG_CENTER_ANGLE  = 3'd6;

	localparam logic [15:0] RST_STEP_INTERVAL = 16'd10;
	localparam logic [15:0] RST_STEP_SIZE     = 16'd1280;
	localparam logic [15:0] RST_DETACH_DELAY  = 16'd500;
	localparam logic [7:0]  RST_MIN_ANGLE     = 8'd0;
	localparam logic [7:0]  RST_MAX_ANGLE     = 8'd180;
	localparam logic [7:0]  RST_CENTER_ANGLE  = 8'd90;
	localparam logic [12:0] RST_DUTY          = 13'd614;
	localparam logic [15:0] CNT_MAX           = 16'hFFFF;

	localparam int unsigned PULSE_MIN_US   = 500;
	localparam int unsigned PULSE_SPAN_US  = 2000;
	localparam int unsigned ANGLE_SPAN     = 180;
	localparam int unsigned DUTY_FULL      = 8191;
	localparam int unsigned PERIOD_US      = 20000;

	typedef logic [255:0][12:0] duty_lut_t;

	function automatic duty_lut_t build_duty_lut();
		duty_lut_t   t;
		int unsigned p;
		for (int i = 0; i < 256; i++) begin
			p = PULSE_MIN_US + (i * PULSE_SPAN_US) / ANGLE_SPAN;
			t[i] = 13'((p * DUTY_FULL) / PERIOD_US);
		end
		return t;
	endfunction

	localparam duty_lut_t DUTY_LUT = build_duty_lut();

	function automatic logic [7:0] limit_angle(input logic [7:0] a, input logic [7:0] lo,
			input logic [7:0] hi);
		logic [7:0] r;
		if (a < lo) begin
			r = lo;
		end else if (a > hi) begin
			r = hi;
		end else begin
			r = a;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/ssl_ctrl.sv =====
// sequencing state machine for the servo slew limiter
module ssl_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output ssl_pkg::cmd_t cmd
);

	ssl_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssl_pkg::ST_IDLE: begin
				if (in_valid) state_d = ssl_pkg::ST_PREP;
			end
			ssl_pkg::ST_PREP:  state_d = ssl_pkg::ST_STEP;
			ssl_pkg::ST_STEP:  state_d = ssl_pkg::ST_APPLY;
			ssl_pkg::ST_APPLY: state_d = ssl_pkg::ST_DUTY;
			ssl_pkg::ST_DUTY:  state_d = ssl_pkg::ST_OUT;
			ssl_pkg::ST_OUT: begin
				if (out_free) state_d = ssl_pkg::ST_IDLE;
			end
			default: state_d = ssl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			ssl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ssl_pkg::ST_PREP:  cmd.prep  = 1'b1;
			ssl_pkg::ST_STEP:  cmd.step  = 1'b1;
			ssl_pkg::ST_APPLY: cmd.apply = 1'b1;
			ssl_pkg::ST_DUTY:  cmd.duty  = 1'b1;
			ssl_pkg::ST_OUT:   cmd.out_load = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssl_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/ssl_dp.sv =====
// angle, counter, duty and configuration datapath for the servo slew limiter
module ssl_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  ssl_pkg::cmd_t cmd,
	input  logic [2:0]    in_op,
	input  logic [7:0]    in_angle,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	output logic [31:0]   out_data
);

	// configuration
	logic [15:0] step_interval_q, step_size_q, detach_delay_q;
	logic        detach_en_q;
	logic [7:0]  min_angle_q, max_angle_q, center_angle_q;

	// servo state
	logic [15:0] angle_now_q, since_step_q, since_move_q;
	logic [7:0]  goal_q;
	logic        pwm_q;
	logic [12:0] duty_q;

	// item and stage registers
	ssl_pkg::op_t op_q;
	logic [7:0]   req_q;
	logic [7:0]   req_lim_s1;
	logic [16:0]  sum_s1, diff_s1;
	logic         below_s1, due_s1, idle_s1;
	logic [15:0]  step_s2;
	logic         take_s2, written_s2;
	logic [31:0]  out_data_q;

	logic [15:0] step_inc, move_inc, goal16, step_pick, lo16, hi16, clamp_lo;
	logic        moving;
	logic        tick_step;

	assign step_inc  = (since_step_q == ssl_pkg::CNT_MAX) ? since_step_q : since_step_q + 16'd1;
	assign move_inc  = (since_move_q == ssl_pkg::CNT_MAX) ? since_move_q : since_move_q + 16'd1;
	assign goal16    = {goal_q, 8'h00};
	assign moving    = angle_now_q[15:8] != goal_q;
	assign tick_step = (op_q == ssl_pkg::OP_TICK) && moving && due_s1;
	assign lo16      = {min_angle_q, 8'h00};
	assign hi16      = {max_angle_q, 8'h00};
	assign clamp_lo  = (step_s2 < lo16) ? lo16 : step_s2;

	always_comb begin
		if (below_s1) begin
			step_pick = (sum_s1 > {1'b0, goal16}) ? goal16 : sum_s1[15:0];
		end else begin
			step_pick = (diff_s1[16] || diff_s1[15:0] < goal16) ? goal16 : diff_s1[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_interval_q <= ssl_pkg::RST_STEP_INTERVAL;
			step_size_q     <= ssl_pkg::RST_STEP_SIZE;
			detach_en_q     <= 1'b0;
			detach_delay_q  <= ssl_pkg::RST_DETACH_DELAY;
			min_angle_q     <= ssl_pkg::RST_MIN_ANGLE;
			max_angle_q     <= ssl_pkg::RST_MAX_ANGLE;
			center_angle_q  <= ssl_pkg::RST_CENTER_ANGLE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ssl_pkg::CFG_STEP_INTERVAL: step_interval_q <= cfg_data;
				ssl_pkg::CFG_STEP_SIZE:     step_size_q     <= cfg_data;
				ssl_pkg::CFG_DETACH_EN:     detach_en_q     <= cfg_data[0];
				ssl_pkg::CFG_DETACH_DELAY:  detach_delay_q  <= cfg_data;
				ssl_pkg::CFG_MIN_ANGLE:     min_angle_q     <= cfg_data[7:0];
				ssl_pkg::CFG_MAX_ANGLE:     max_angle_q     <= cfg_data[7:0];
				ssl_pkg::CFG_CENTER_ANGLE:  center_angle_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= ssl_pkg::op_t'(in_op);
			req_q <= in_angle;
		end
		if (cmd.prep) begin
			req_lim_s1 <= ssl_pkg::limit_angle(req_q, min_angle_q, max_angle_q);
			sum_s1     <= {1'b0, angle_now_q} + {1'b0, step_size_q};
			diff_s1    <= {1'b0, angle_now_q} - {1'b0, step_size_q};
			below_s1   <= angle_now_q < goal16;
			due_s1     <= step_inc >= step_interval_q;
			idle_s1    <= move_inc >= detach_delay_q;
		end
		if (cmd.step) begin
			step_s2    <= step_pick;
			take_s2    <= tick_step;
			written_s2 <= tick_step || op_q == ssl_pkg::OP_SET || op_q == ssl_pkg::OP_RECENTRE;
		end
		if (cmd.out_load) begin
			out_data_q <= {moving, goal_q, angle_now_q[15:8], pwm_q, written_s2, duty_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_now_q  <= {ssl_pkg::RST_CENTER_ANGLE, 8'h00};
			goal_q       <= ssl_pkg::RST_CENTER_ANGLE;
			since_step_q <= '0;
			since_move_q <= '0;
			pwm_q        <= 1'b1;
			duty_q       <= ssl_pkg::RST_DUTY;
		end else begin
			if (cmd.prep && op_q == ssl_pkg::OP_TICK) begin
				since_step_q <= step_inc;
				since_move_q <= move_inc;
			end
			if (cmd.step) begin
				case (op_q)
					ssl_pkg::OP_TICK: begin
						if (moving && due_s1) begin
							since_step_q <= '0;
							since_move_q <= '0;
							pwm_q        <= 1'b1;
						end else if (!moving && detach_en_q && pwm_q && idle_s1) begin
							pwm_q <= 1'b0;
						end
					end
					ssl_pkg::OP_RAMP: begin
						goal_q       <= req_lim_s1;
						since_move_q <= '0;
						pwm_q        <= 1'b1;
					end
					ssl_pkg::OP_SET: begin
						goal_q       <= req_lim_s1;
						angle_now_q  <= {req_lim_s1, 8'h00};
						since_move_q <= '0;
						pwm_q        <= 1'b1;
					end
					ssl_pkg::OP_STOP: pwm_q <= 1'b0;
					ssl_pkg::OP_RECENTRE: begin
						goal_q       <= center_angle_q;
						angle_now_q  <= {center_angle_q, 8'h00};
						since_step_q <= '0;
						since_move_q <= '0;
						pwm_q        <= 1'b1;
					end
					default: ;
				endcase
			end
			if (cmd.apply && take_s2) begin
				angle_now_q <= (clamp_lo > hi16) ? hi16 : clamp_lo;
			end
			if (cmd.duty && written_s2) begin
				duty_q <= ssl_pkg::DUTY_LUT[ssl_pkg::limit_angle(angle_now_q[15:8],
					min_angle_q, max_angle_q)];
			end
		end
	end

	assign out_data = out_data_q;

endmodule

// ===== hw/rtl/servo_slew_limiter_pwm.sv =====
// servo slew limiter with 50 Hz pwm duty, top level
//
// Each input word is one operation (tuser) with a requested angle in degrees
// (tdata): tick, ramp to angle, set immediately, stop, recentre. Every word
// gives exactly one output word with the held duty, a duty-written flag, the
// pwm enable, the current and target angles and a moving flag.
// Configuration registers are written on the cfg channel, which is always
// ready; write them only while no word is in flight.
// A word is taken when the block is idle and goes through a fixed sequence:
// prepare, step, clamp, duty lookup, output. Output valid rises when the
// output register loads, and the input is ready again from that edge, so
// the next word is taken only after the current one reaches the output
// register; the sequencer handles one word at a time.
// If the receiver stalls, the finished word holds in the output register and
// the next word is processed up to the output stage, where it waits.
// Reset sets the angle and target to 90 degrees, duty to 614, pwm on, and the
// configuration registers to their defaults.
module servo_slew_limiter_pwm (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // angle[7:0]
	input  logic [2:0]  s_axis_tuser,   // operation[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// duty[12:0], duty_written[13], pwm_on[14], pos_deg[22:15],
	// aim_deg[30:23], moving[31]
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	ssl_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	ssl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	ssl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_op     (s_axis_tuser),
		.in_angle  (s_axis_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (m_axis_tdata)
	);

endmodule

// ===== hw/rtl/ssl_checker.sv =====
// port checker for the servo slew limiter, bound to the top level
`include "servo_slew_limiter_pwm_defines.svh"

module ssl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic [2:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [2:0]  cfg_index,
	input logic [15:0] cfg_data
);

	// stalled word holds
	`SSL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")

	// one word in flight
	`SSL_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after accept")

	// moving flag agrees with the angles
	`SSL_ASSERT_NOW(a_moving_flag, m_axis_tvalid, m_axis_tdata[31] == (m_axis_tdata[22:15] != m_axis_tdata[30:23]), "moving flag inconsistent")

	// a duty update always drives the pwm
	`SSL_ASSERT_NOW(a_written_pwm_on, m_axis_tvalid && m_axis_tdata[13], m_axis_tdata[14], "duty written with pwm off")

endmodule

bind servo_slew_limiter_pwm ssl_checker u_ssl_checker (.*);
